// ----- rtl/kway_run_merge_core_assert.svh -----
// Assertion macros used by the port-level checker of the merge core
`ifndef KWAY_RUN_MERGE_CORE_ASSERT_SVH
`define KWAY_RUN_MERGE_CORE_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent in the next cycle
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kwm_pkg.sv -----
// Types and constants of the k-way run merge core
package kwm_pkg;

  localparam int MAX_RUNS    = 7;
  localparam int RUN_RECORDS = 7;

  localparam int RUN_W  = 3;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  localparam int FILL_W = $clog2(RUN_RECORDS + 1);
  localparam int SLOT_W = (RUN_RECORDS > 1) ? $clog2(RUN_RECORDS) : 1;

  typedef struct packed {
    logic [RUN_W-1:0] run_number;
    logic [KEY_W-1:0] record_key;
    logic [PAY_W-1:0] record_payload;
    logic             load_done;
  } kwm_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [RUN_W-1:0] source_run;
    logic             final_record;
  } kwm_out_t;

  // search token passed along the cell row
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [RUN_W-1:0] run;
  } kwm_tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             load;
    logic             pop;
    logic             clear;
    logic [RUN_W-1:0] sel;
    logic [RUN_W-1:0] active;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } kwm_ctl_t;

endpackage

// ----- rtl/kway_run_merge_core.sv -----
// Records load at one per cycle while in_ready is high; load_done starts the merge and drops
// in_ready until it ends. For each merged record a start cycle launches a search token down the
// registered row of MAX_RUNS run cells, then a decision cycle pops the winner; output stalls
// can hold the decision. The final record leaves after one more search, and that last decision
// cycle also empties every run.
module kway_run_merge_core
  import kwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kwm_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kwm_out_t         out_data,
  input  logic             cfg_we,
  input  logic [RUN_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [RUN_W-1:0] active_r;
  logic             start_r, start_nxt;
  kwm_tok_t         cand_r, cand_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  kwm_out_t         pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  kwm_out_t         out_r, out_nxt;

  kwm_ctl_t         ctl;
  kwm_tok_t         start_tok;
  kwm_tok_t         chain [MAX_RUNS];

  logic in_acc, out_free;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign start_tok = '{valid: start_r, found: 1'b0, key: '0, payload: '0, run: '0};

  for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
    kwm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(RUN_W'(i)),
      .ctl     (ctl),
      .tok_in  ((i == 0) ? start_tok : chain[(i > 0) ? i - 1 : 0]),
      .tok_out (chain[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = 1'b0;
    cand_nxt       = cand_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    ctl         = '0;
    ctl.active  = active_r;
    ctl.key     = in_data.record_key;
    ctl.payload = in_data.record_payload;
    ctl.sel     = in_data.run_number;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          ctl.load = 1'b1;
          if (in_data.load_done) begin
            start_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chain[MAX_RUNS-1].valid) begin
          cand_nxt  = chain[MAX_RUNS-1];
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // a winner is held back one search so the last one can be marked final
        if (cand_r.found) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = '{out_key: cand_r.key, out_payload: cand_r.payload,
                               source_run: cand_r.run, final_record: 1'b0};
            ctl.pop   = 1'b1;
            ctl.sel   = cand_r.run;
            start_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end else if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt        = 1'b1;
            out_nxt              = pend_r;
            out_nxt.final_record = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          ctl.clear      = 1'b1;
          state_nxt      = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      active_r     <= RUN_W'(7);
      start_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/kwm_cell.sv -----
// One run cell: holds a run as a shift queue and takes part in the head search
module kwm_cell
  import kwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [RUN_W-1:0] cell_idx,
  input  kwm_ctl_t         ctl,
  input  kwm_tok_t         tok_in,
  output kwm_tok_t         tok_out
);

  logic [KEY_W-1:0]  key_r [RUN_RECORDS];
  logic [PAY_W-1:0]  pay_r [RUN_RECORDS];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  kwm_tok_t          tok_r, tok_nxt;

  logic sel_me, do_load, do_pop, own_ok, take;

  assign sel_me  = (ctl.sel == cell_idx);
  assign do_load = ctl.load && sel_me && (fill_r < FILL_W'(RUN_RECORDS));
  assign do_pop  = ctl.pop && sel_me;
  assign own_ok  = (cell_idx < ctl.active) && (fill_r != '0);
  // strict compare: on a tie the lower run, seen earlier in the row, keeps it
  assign take    = own_ok && (!tok_in.found || (key_r[0] < tok_in.key));

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clear) begin
      fill_nxt = '0;
    end else if (do_load) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (do_pop) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && take) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.key     = key_r[0];
      tok_nxt.payload = pay_r[0];
      tok_nxt.run     = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      key_r[fill_r[SLOT_W-1:0]] <= ctl.key;
      pay_r[fill_r[SLOT_W-1:0]] <= ctl.payload;
    end else if (do_pop) begin
      for (int j = 0; j < RUN_RECORDS - 1; j++) begin
        key_r[j] <= key_r[j+1];
        pay_r[j] <= pay_r[j+1];
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/kwm_checker.sv -----
// Port-level checks for the merge core, bound to the top level
`include "kway_run_merge_core_assert.svh"

module kwm_checker
  import kwm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input kwm_in_t          in_data,
  input logic             out_valid,
  input logic             out_ready,
  input kwm_out_t         out_data,
  input logic             cfg_we
);

  // a stalled result request holds
  `KWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result moved")

  // load_done closes the input side for the merge
  `KWM_ASSERT_NEXT(a_merge_busy, in_valid && in_ready && in_data.load_done, !in_ready, "input open")

  // a result names a run that exists
  `KWM_ASSERT_NOW(a_run_range, out_valid, out_data.source_run < RUN_W'(MAX_RUNS), "bad run")

  // configuration is only written with the core idle and no result pending
  `KWM_ASSERT_NOW(a_cfg_idle, cfg_we, !out_valid && in_ready, "config write mid merge")

endmodule

bind kway_run_merge_core kwm_checker u_kwm_checker (.*);

// ----- bench/kwm_merge_checker.sv -----
// Channel monitor for the merge core: predicts the merged record stream and counts mismatches
`timescale 1ns / 100ps
module kwm_merge_checker
  import kwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  kwm_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  kwm_out_t         out_data,
  input  logic             cfg_we,
  input  logic [RUN_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               n_waiting
);

  logic [KEY_W-1:0] key_mem [MAX_RUNS][RUN_RECORDS];
  logic [PAY_W-1:0] pay_mem [MAX_RUNS][RUN_RECORDS];
  int               run_fill [MAX_RUNS];
  int               run_head [MAX_RUNS];
  logic [RUN_W-1:0] active_runs = RUN_W'(MAX_RUNS);
  kwm_out_t         merged_q [$];
  int               errs = 0;

  initial begin
    fail_count = 0;
    n_waiting  = 0;
  end

  task automatic clear_runs();
    for (int r = 0; r < MAX_RUNS; r++) begin
      run_fill[r] = 0;
      run_head[r] = 0;
    end
  endtask

  task automatic store_record(kwm_in_t rec);
    int r;
    r = int'(rec.run_number);
    if (r < MAX_RUNS && run_fill[r] < RUN_RECORDS) begin
      key_mem[r][run_fill[r]] = rec.record_key;
      pay_mem[r][run_fill[r]] = rec.record_payload;
      run_fill[r]++;
    end
  endtask

  // smallest head key wins, lowest run on a tie; the record is held back one
  // round so the last one can be flagged
  task automatic merge_runs();
    int               lim;
    bit               found;
    bit               held_ok;
    int               pick;
    logic [KEY_W-1:0] best;
    kwm_out_t         held;
    lim = (int'(active_runs) > MAX_RUNS) ? MAX_RUNS : int'(active_runs);
    held_ok = 1'b0;
    held = '0;
    do begin
      found = 1'b0;
      pick = 0;
      best = '0;
      for (int r = 0; r < lim; r++) begin
        if (run_head[r] < run_fill[r]) begin
          if (!found || key_mem[r][run_head[r]] < best) begin
            found = 1'b1;
            best = key_mem[r][run_head[r]];
            pick = r;
          end
        end
      end
      if (found) begin
        if (held_ok) merged_q = {merged_q, held};
        held.out_key      = best;
        held.out_payload  = pay_mem[pick][run_head[pick]];
        held.source_run   = RUN_W'(pick);
        held.final_record = 1'b0;
        held_ok = 1'b1;
        run_head[pick]++;
      end
    end while (found);
    if (held_ok) begin
      held.final_record = 1'b1;
      merged_q = {merged_q, held};
    end
    clear_runs();
  endtask

  always @(posedge clk) begin
    kwm_out_t want;
    if (!rst_n) begin
      clear_runs();
      merged_q.delete();
      active_runs = RUN_W'(MAX_RUNS);
    end else begin
      if (cfg_we) active_runs = cfg_wdata;
      if (out_valid && out_ready) begin
        if (merged_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected merged record key=%h pay=%h run=%0d last=%b", $time,
                   out_data.out_key, out_data.out_payload, out_data.source_run,
                   out_data.final_record);
        end else begin
          want = merged_q.pop_front();
          if (out_data.out_key !== want.out_key || out_data.out_payload !== want.out_payload ||
              out_data.source_run !== want.source_run ||
              out_data.final_record !== want.final_record) begin
            errs++;
            $display("%0t: mismatch exp k=%h p=%h r=%0d l=%b got k=%h p=%h r=%0d l=%b",
                     $time, want.out_key, want.out_payload, want.source_run,
                     want.final_record, out_data.out_key, out_data.out_payload,
                     out_data.source_run, out_data.final_record);
          end
        end
      end
      if (in_valid && in_ready) begin
        store_record(in_data);
        if (in_data.load_done) merge_runs();
      end
    end
    n_waiting  = merged_q.size();
    fail_count = errs;
  end

endmodule

// ----- bench/tb.sv -----
// Stimulus, idling control and verdict for the k-way run merge core
`timescale 1ns / 100ps
module tb;
  import kwm_pkg::*;

  // one empty search plus the clearing cycle, with margin
  localparam int SETTLE      = 4 * (MAX_RUNS + 1) + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 30;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  kwm_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  kwm_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [RUN_W-1:0] cfg_wdata = '0;

  int tx_idle = 7;
  int rx_idle = 69;
  int fail_count;
  int n_waiting;
  int cycles = 0;
  int sent = 0;

  kway_run_merge_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kwm_merge_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .n_waiting  (n_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic kwm_in_t mk_rec(int run, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                     logic done);
    kwm_in_t rec;
    rec.run_number     = RUN_W'(run);
    rec.record_key     = k;
    rec.record_payload = p;
    rec.load_done      = done;
    return rec;
  endfunction

  // called just after a falling edge; leaves valid high so back-to-back requests need no toggle
  task automatic send(kwm_in_t rec);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (n_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_active(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= RUN_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // sorted runs with random content, interleaved in random order
  task automatic send_sorted_batch();
    int               cnt [MAX_RUNS];
    int               taken [MAX_RUNS];
    logic [KEY_W-1:0] keys [MAX_RUNS][RUN_RECORDS];
    logic [KEY_W-1:0] k;
    int               total;
    int               r;
    bit               narrow;
    narrow = $urandom_range(0, 1);
    total = 0;
    for (int i = 0; i < MAX_RUNS; i++) begin
      cnt[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(0, RUN_RECORDS)
                                           : $urandom_range(0, 2);
      taken[i] = 0;
      total += cnt[i];
      k = narrow ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
      for (int s = 0; s < RUN_RECORDS; s++) begin
        keys[i][s] = k;
        // narrow keys tie often; wide steps never wrap past the top
        k = narrow ? k + KEY_W'($urandom_range(0, 3)) : k + KEY_W'($urandom_range(0, (~k) >> 3));
      end
    end
    if (total == 0) begin
      cnt[0] = 1;
      total = 1;
    end
    while (total > 0) begin
      r = $urandom_range(0, MAX_RUNS - 1);
      if (taken[r] < cnt[r]) begin
        send(mk_rec(r, keys[r][taken[r]], $urandom, total == 1));
        taken[r]++;
        total--;
      end
    end
  endtask

  // unsorted keys, stray run numbers and overfilled runs
  task automatic send_noise_batch();
    int n;
    int r;
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      r = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_RUNS);
      send(mk_rec(r, $urandom, $urandom, i == n - 1));
    end
  endtask

  function automatic int pick_active();
    case ($urandom_range(0, 3))
      0: return 1;
      1: return MAX_RUNS;
      2: return $urandom_range(2, MAX_RUNS - 1);
      default: return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_RUNS);
    endcase
  endfunction

  initial begin
    int goal;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // key and payload extremes, a tie between runs 1 and 3, a stray run number
    send(mk_rec(0, '0, '1, 1'b0));
    send(mk_rec(MAX_RUNS - 1, '1, '0, 1'b0));
    send(mk_rec(3, 32'd5, 32'h5555_5555, 1'b0));
    send(mk_rec(1, 32'd5, 32'hAAAA_AAAA, 1'b0));
    send(mk_rec(MAX_RUNS, 32'd1, 32'h0BAD_0BAD, 1'b0));
    send(mk_rec(2, 32'h8000_0000, 32'h1234_5678, 1'b1));

    // load_done on a stray record with every run empty
    send(mk_rec(MAX_RUNS, 32'd9, 32'd9, 1'b1));
    drain();

    // one record too many for run 4, run 5 loaded out of order
    for (int i = 0; i <= RUN_RECORDS; i++)
      send(mk_rec(4, 32'd10 + i, 32'hC0DE_0000 + i, 1'b0));
    send(mk_rec(5, 32'd9, 32'hFEED_0001, 1'b0));
    send(mk_rec(5, 32'd3, 32'hFEED_0002, 1'b1));

    // a single active run; the record in run 2 must be dropped with the clear
    set_active(1);
    send(mk_rec(0, 32'd7, 32'd70, 1'b0));
    send(mk_rec(2, 32'd1, 32'd10, 1'b0));
    send(mk_rec(0, 32'd4, 32'd40, 1'b1));

    // no active run at all
    set_active(0);
    send(mk_rec(0, 32'd3, 32'd30, 1'b1));
    set_active(MAX_RUNS);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      @(posedge clk);
      tx_idle = (ph == 0) ? 7 : (ph == 1) ? 69 : 0;
      rx_idle = (ph == 0) ? 69 : (ph == 1) ? 7 : 0;
      @(negedge clk);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        if ($urandom_range(0, 4) == 0) set_active(pick_active());
        if ($urandom_range(0, 4) == 0) send_noise_batch();
        else send_sorted_batch();
      end
    end

    drain();
    if (fail_count == 0 && n_waiting == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- kway_run_merge_core.f -----
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_cell.sv
rtl/kway_run_merge_core.sv
rtl/kwm_checker.sv
bench/kwm_merge_checker.sv
bench/tb.sv
